// File: rtl/core/acs_pkg.sv
package acs_pkg;

    // Field widths
    localparam int unsigned CmdW  = 16;
    localparam int unsigned CoefW = 16;
    localparam int unsigned DiffW = CmdW + 1;
    localparam int unsigned CfgIdxW = 3;

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_FWD_RISE  = 3'd0,
        CFG_FWD_FALL  = 3'd1,
        CFG_YAW_RISE  = 3'd2,
        CFG_YAW_FALL  = 3'd3,
        CFG_REV_RISE  = 3'd4,
        CFG_REV_FALL  = 3'd5,
        CFG_SLOW      = 3'd6,
        CFG_YAW_SMOOTH = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [CoefW-1:0] FwdRiseRst = 16'd49152;
    localparam logic [CoefW-1:0] FwdFallRst = 16'd62259;
    localparam logic [CoefW-1:0] YawRiseRst = 16'd55706;
    localparam logic [CoefW-1:0] YawFallRst = 16'd62259;
    localparam logic [CoefW-1:0] RevRiseRst = 16'd55706;
    localparam logic [CoefW-1:0] RevFallRst = 16'd49152;
    localparam logic [CoefW-1:0] SlowRst    = 16'd16384;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LOAD,
        ST_SMOOTH,
        ST_DONE
    } t_state;

    // Start request to a serial multiplier
    typedef struct packed {
        logic                    start;
        logic signed [DiffW-1:0] a;
        logic        [CoefW-1:0] coef;
    } t_mul_req;

endpackage

// File: rtl/core/acs_if.sv
interface acs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] fwd_cmd;
    logic signed [15:0] yaw_cmd;
    logic               reverse_mode;
    logic               stop_hold;
    logic               slow_on;

    modport source (output valid, fwd_cmd, yaw_cmd, reverse_mode, stop_hold, slow_on,
                    input ready);
    modport sink   (input valid, fwd_cmd, yaw_cmd, reverse_mode, stop_hold, slow_on,
                    output ready);
endinterface

interface acs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] fwd_out;
    logic signed [15:0] yaw_out;

    modport source (output valid, fwd_out, yaw_out, input ready);
    modport sink   (input valid, fwd_out, yaw_out, output ready);
endinterface

// File: rtl/core/acs_serial_mul.sv
module acs_serial_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  acs_pkg::t_mul_req                 i_req,
    output logic                              o_done,
    output logic signed [acs_pkg::DiffW-1:0]  o_prod
);
    import acs_pkg::*;

    localparam int unsigned AccW = DiffW + 1;
    localparam int unsigned CntW = $clog2(CoefW);
    localparam logic [CntW-1:0] LastCnt = CntW'(CoefW - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CntW-1:0]         r_cnt;
    logic signed [DiffW-1:0] r_a;
    logic [CoefW-1:0]        r_coef;
    logic signed [AccW-1:0]  r_acc;

    logic signed [AccW:0]    n_sum;

    // One coefficient bit per cycle, LSB first; each step shifts right with floor
    always_comb begin
        n_sum = {r_acc[AccW-1], r_acc};
        if (r_coef[0]) begin
            n_sum = n_sum + {{2{r_a[DiffW-1]}}, r_a};
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastCnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.a;
            r_coef <= i_req.coef;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_coef <= r_coef >> 1;
            r_acc  <= n_sum[AccW:1];
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[DiffW-1:0];

endmodule

// File: rtl/core/asymmetric_command_smoother.sv
// Two-channel velocity command smoother (forward speed, yaw rate, Q3.12).
// Input channel i_cmd: valid/ready, one command item per handshake.
// Output channel o_res: valid/ready, one smoothed item per command item,
// none for an item that carries stop_hold (its state is left unchanged).
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write one coefficient
// register per clock; write only while the block is idle.
// Processing: commands go through two bit-serial multipliers, one per channel,
// one coefficient bit per cycle. Slow-down scaling takes one pass and
// smoothing another. The next item can be accepted in the cycle after the
// result is loaded into the output register, so a new item is not taken
// while the last one is still being computed.
// Reset (synchronous, active low) loads the default coefficients, clears
// both channel memories and empties the output register.
// A stalled receiver holds the result in the output register; one further
// item is accepted and computed, then waits until the register frees.
module asymmetric_command_smoother (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    acs_in_if.sink                            i_cmd,
    acs_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [acs_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [acs_pkg::CoefW-1:0]         i_cfg_data
);
    import acs_pkg::*;

    // Configuration registers
    logic [CoefW-1:0] r_fwd_rise, r_fwd_fall, r_yaw_rise, r_yaw_fall;
    logic [CoefW-1:0] r_rev_rise, r_rev_fall, r_slow;
    logic             r_yaw_smooth;

    // Item and channel state
    t_state                 r_state, n_state;
    logic signed [CmdW-1:0] r_fwd, r_yaw;
    logic                   r_rev;
    logic signed [CmdW-1:0] r_prev_fwd, r_prev_yaw;
    logic                   r_out_valid;
    logic signed [CmdW-1:0] r_fwd_out, r_yaw_out;

    t_mul_req                mul_req_f, mul_req_y;
    logic                    done_f, done_y;
    logic signed [DiffW-1:0] prod_f, prod_y;

    logic accept, out_free, load_out;
    logic signed [DiffW-1:0] sum_f, sum_y;
    logic signed [CmdW-1:0]  fo, yo, n_prev_yaw;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign load_out    = (r_state == ST_DONE) && out_free;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_rise   <= FwdRiseRst;
            r_fwd_fall   <= FwdFallRst;
            r_yaw_rise   <= YawRiseRst;
            r_yaw_fall   <= YawFallRst;
            r_rev_rise   <= RevRiseRst;
            r_rev_fall   <= RevFallRst;
            r_slow       <= SlowRst;
            r_yaw_smooth <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FWD_RISE:   r_fwd_rise   <= i_cfg_data;
                CFG_FWD_FALL:   r_fwd_fall   <= i_cfg_data;
                CFG_YAW_RISE:   r_yaw_rise   <= i_cfg_data;
                CFG_YAW_FALL:   r_yaw_fall   <= i_cfg_data;
                CFG_REV_RISE:   r_rev_rise   <= i_cfg_data;
                CFG_REV_FALL:   r_rev_fall   <= i_cfg_data;
                CFG_SLOW:       r_slow       <= i_cfg_data;
                CFG_YAW_SMOOTH: r_yaw_smooth <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Multiplier requests: scale pass from the input, smoothing pass from the item
    always_comb begin
        mul_req_f = '0;
        mul_req_y = '0;
        unique case (r_state)
            ST_IDLE: begin
                mul_req_f.start = accept && !i_cmd.stop_hold && i_cmd.slow_on;
                mul_req_f.a     = DiffW'(i_cmd.fwd_cmd);
                mul_req_f.coef  = r_slow;
                mul_req_y.start = mul_req_f.start;
                mul_req_y.a     = DiffW'(i_cmd.yaw_cmd);
                mul_req_y.coef  = r_slow;
            end
            ST_LOAD: begin
                mul_req_f.start = 1'b1;
                mul_req_f.a     = DiffW'(r_prev_fwd) - DiffW'(r_fwd);
                if (r_fwd > r_prev_fwd) begin
                    mul_req_f.coef = r_rev ? r_rev_rise : r_fwd_rise;
                end else begin
                    mul_req_f.coef = r_rev ? r_rev_fall : r_fwd_fall;
                end
                mul_req_y.start = 1'b1;
                mul_req_y.a     = DiffW'(r_prev_yaw) - DiffW'(r_yaw);
                mul_req_y.coef  = (r_yaw > r_prev_yaw) ? r_yaw_rise : r_yaw_fall;
            end
            default: ;
        endcase
    end

    acs_serial_mul u_mul_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req_f),
        .o_done  (done_f),
        .o_prod  (prod_f)
    );

    acs_serial_mul u_mul_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req_y),
        .o_done  (done_y),
        .o_prod  (prod_y)
    );

    // Filter outputs; the result lies between command and memory, so no saturation
    always_comb begin
        sum_f = DiffW'(r_fwd) + prod_f;
        sum_y = DiffW'(r_yaw) + prod_y;
        fo    = (r_fwd == '0) ? '0 : sum_f[CmdW-1:0];
        if (r_yaw == '0) begin
            yo         = '0;
            n_prev_yaw = '0;
        end else if (r_yaw_smooth) begin
            yo         = sum_y[CmdW-1:0];
            n_prev_yaw = sum_y[CmdW-1:0];
        end else begin
            yo         = r_yaw;
            n_prev_yaw = r_prev_yaw;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !i_cmd.stop_hold) begin
                    n_state = i_cmd.slow_on ? ST_SCALE : ST_LOAD;
                end
            end
            ST_SCALE:  if (done_f) n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_SMOOTH;
            ST_SMOOTH: if (done_f) n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd <= i_cmd.fwd_cmd;
            r_yaw <= i_cmd.yaw_cmd;
            r_rev <= i_cmd.reverse_mode;
        end else if (r_state == ST_SCALE && done_f && done_y) begin
            r_fwd <= prod_f[CmdW-1:0];
            r_yaw <= prod_y[CmdW-1:0];
        end
    end

    // Channel memories and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_fwd  <= '0;
            r_prev_yaw  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_prev_fwd  <= fo;
                r_prev_yaw  <= n_prev_yaw;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_fwd_out <= fo;
            r_yaw_out <= yo;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.fwd_out = r_fwd_out;
    assign o_res.yaw_out = r_yaw_out;

endmodule
